FILE: rtl/core/sha1sh_pkg.sv
// Shared constants for the SHA-1 stream hasher: chaining-word initial values,
// round constants, state codes and field widths.
// No dependencies.
package sha1sh_pkg;

    localparam int NUM_WORDS  = 5;
    localparam int WIN_DEPTH  = 16;
    localparam int NUM_ROUNDS = 80;
    localparam int CNT_W      = 61;
    localparam int RND_W      = 7;
    localparam int IDX_W      = 3;

    typedef logic [31:0] word_t;
    typedef word_t       hvec_t [NUM_WORDS];

    localparam word_t H_INIT0 = 32'h6745_2301;
    localparam word_t H_INIT1 = 32'hEFCD_AB89;
    localparam word_t H_INIT2 = 32'h98BA_DCFE;
    localparam word_t H_INIT3 = 32'h1032_5476;
    localparam word_t H_INIT4 = 32'hC3D2_E1F0;

    localparam word_t K_ROUND0 = 32'h5A82_7999;
    localparam word_t K_ROUND1 = 32'h6ED9_EBA1;
    localparam word_t K_ROUND2 = 32'h8F1B_BCDC;
    localparam word_t K_ROUND3 = 32'hCA62_C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_LEN  = 3'd2;
    localparam logic [2:0] ST_COMP = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    // which block is being compressed
    localparam logic [1:0] PH_DATA  = 2'd0;
    localparam logic [1:0] PH_PAD   = 2'd1;
    localparam logic [1:0] PH_FINAL = 2'd2;

    function automatic word_t rotl(input word_t x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

endpackage

FILE: rtl/core/sha1_stream_hasher.sv
// SHA-1 stream hasher: byte packing, padding, iterative 80-round compression
// and digest output. Depends on sha1sh_pkg.
//
// Bytes come in one per transfer and go straight into a 16-word schedule
// window, big-endian. The 64th byte of a block starts a compression (one
// round a cycle through a single shared round adder) and then a fold into
// the chaining words, during which s_tready is low. A transfer with tlast
// then pads and runs one final compression, or two when 56 or more bytes
// of the last block are filled (the length block is loaded between them),
// and then presents the five digest words h0..h4, one per output transfer,
// m_tlast on h4. The input is not taken again until h4 has been transferred;
// the chaining words and byte count are then back at their initial values
// for the next message.
module sha1_stream_hasher
    import sha1sh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);

    logic [2:0]       state_reg, state_next;
    logic [1:0]       ph_reg, ph_next;
    logic             fin_reg, fin_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    hvec_t            h_reg, h_next;
    word_t            w_reg [WIN_DEPTH];
    word_t            w_next [WIN_DEPTH];
    hvec_t            v_reg, v_next;

    logic [5:0]  fill;
    logic [63:0] bit_len;
    word_t       w_round, f_round, k_round, sum_round;

    assign fill    = cnt_reg[5:0];
    assign bit_len = {cnt_reg, 3'b000};

    // round function
    always_comb begin
        if (rnd_reg < RND_W'(WIN_DEPTH)) begin
            w_round = w_reg[0];
        end else begin
            w_round = rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
        end
        if (rnd_reg inside {[0:19]}) begin
            f_round = (v_reg[1] & v_reg[2]) | (~v_reg[1] & v_reg[3]);
            k_round = K_ROUND0;
        end else if (rnd_reg inside {[20:39]}) begin
            f_round = v_reg[1] ^ v_reg[2] ^ v_reg[3];
            k_round = K_ROUND1;
        end else if (rnd_reg inside {[40:59]}) begin
            f_round = (v_reg[1] & v_reg[2]) | (v_reg[1] & v_reg[3])
                    | (v_reg[2] & v_reg[3]);
            k_round = K_ROUND2;
        end else begin
            f_round = v_reg[1] ^ v_reg[2] ^ v_reg[3];
            k_round = K_ROUND3;
        end
        sum_round = rotl(v_reg[0], 5) + f_round + v_reg[4] + k_round + w_round;
    end

    always_comb begin
        logic [5:0] pos;
        state_next = state_reg;
        ph_next    = ph_reg;
        fin_next   = fin_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        h_next     = h_reg;
        w_next     = w_reg;
        v_next     = v_reg;
        pos        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0]) begin
                        w_next[fill[5:2]][{~fill[1:0], 3'b000} +: 8] = s_tdata;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (s_tuser[0] && (fill == 6'd63)) begin
                        state_next = ST_COMP;
                        ph_next    = PH_DATA;
                        fin_next   = s_tlast;
                        rnd_next   = '0;
                    end else if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                for (int i = 0; i < WIN_DEPTH; i++) begin
                    for (int j = 0; j < 4; j++) begin
                        pos = 6'(4 * i + j);
                        if (pos == fill) begin
                            w_next[i][8*(3-j) +: 8] = PAD_BYTE;
                        end else if (pos > fill) begin
                            w_next[i][8*(3-j) +: 8] = 8'h00;
                        end
                    end
                end
                if (fill >= 6'd56) begin
                    ph_next = PH_PAD;
                end else begin
                    w_next[14] = bit_len[63:32];
                    w_next[15] = bit_len[31:0];
                    ph_next    = PH_FINAL;
                end
                state_next = ST_COMP;
                rnd_next   = '0;
            end
            ST_LEN: begin
                for (int i = 0; i < WIN_DEPTH - 2; i++) begin
                    w_next[i] = '0;
                end
                w_next[14] = bit_len[63:32];
                w_next[15] = bit_len[31:0];
                ph_next    = PH_FINAL;
                state_next = ST_COMP;
                rnd_next   = '0;
            end
            ST_COMP: begin
                for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[WIN_DEPTH-1] = w_round;
                v_next[4] = v_reg[3];
                v_next[3] = v_reg[2];
                v_next[2] = rotl(v_reg[1], 30);
                v_next[1] = v_reg[0];
                v_next[0] = sum_round;
                rnd_next  = rnd_reg + RND_W'(1);
                if (rnd_reg == RND_W'(NUM_ROUNDS - 1)) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < NUM_WORDS; i++) begin
                    h_next[i] = h_reg[i] + v_reg[i];
                end
                case (ph_reg)
                    PH_DATA:  state_next = fin_reg ? ST_PAD : ST_IDLE;
                    PH_PAD:   state_next = ST_LEN;
                    PH_FINAL: begin
                        state_next = ST_EMIT;
                        idx_next   = '0;
                    end
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_EMIT: begin
                if (m_tready) begin
                    if (idx_reg == IDX_W'(NUM_WORDS - 1)) begin
                        h_next     = '{H_INIT0, H_INIT1, H_INIT2, H_INIT3, H_INIT4};
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // load working variables on entry to a compression
        if ((state_next == ST_COMP) && (state_reg != ST_COMP)) begin
            v_next = h_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ph_reg    <= PH_DATA;
            fin_reg   <= 1'b0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            h_reg     <= '{H_INIT0, H_INIT1, H_INIT2, H_INIT3, H_INIT4};
        end else begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            fin_reg   <= fin_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            h_reg     <= h_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg <= w_next;
        v_reg <= v_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = h_reg[idx_reg];
    assign m_tuser  = idx_reg;
    assign m_tlast  = (idx_reg == IDX_W'(NUM_WORDS - 1));

endmodule

FILE: rtl/core/sha1sh_checker.sv
// Port-level checks for sha1_stream_hasher, attached by bind.
// Depends on sha1sh_pkg.
module sha1sh_checker
    import sha1sh_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // input is held off while the digest is out
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while digest pending");

    // a transfer without tlast produces no digest word next cycle
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tlast) |=> !m_tvalid)
        else $error("digest word without end of message");

    // digest words follow one another in index order
    a_word_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast)
            |=> (m_tvalid && (m_tuser == $past(m_tuser) + 3'd1)))
        else $error("digest word index out of sequence");

    // tlast only on the final digest word
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == 3'(NUM_WORDS - 1))))
        else $error("tlast not aligned with final word");

    // stalled output holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output changed while stalled");

endmodule

bind sha1_stream_hasher sha1sh_checker u_sha1sh_checker (.*);

FILE: test/sha1_digest_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Digest scoreboard for the SHA-1 stream hasher test: a bit-true SHA-1 predictor
// fed by every accepted input transfer, and an in-order check of the digest words.
// No dependencies.
package sha1_digest_sb_pkg;

    class sha1_digest_scoreboard;

        typedef struct {
            logic [31:0] word;
            logic [2:0]  index;
            logic        last;
        } digest_beat_t;

        logic [31:0]  chain_h [5];
        logic [7:0]   msg_block [64];
        logic [60:0]  msg_len_bytes;
        digest_beat_t digest_q [$];
        int unsigned  errors;
        int unsigned  words_checked;
        int unsigned  messages;

        function new();
            errors = 0;
            words_checked = 0;
            messages = 0;
            foreach (msg_block[i]) msg_block[i] = 8'h00;
            restart();
        endfunction

        function void restart();
            chain_h[0] = 32'h6745_2301;
            chain_h[1] = 32'hEFCD_AB89;
            chain_h[2] = 32'h98BA_DCFE;
            chain_h[3] = 32'h1032_5476;
            chain_h[4] = 32'hC3D2_E1F0;
            msg_len_bytes = '0;
        endfunction

        function logic [31:0] rol(logic [31:0] x, int unsigned n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function void compress_block();
            logic [31:0] w [16];
            logic [31:0] a, b, c, d, e, f, k, nw, sum;
            int t;
            for (t = 0; t < 16; t++) begin
                w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
            end
            a = chain_h[0];
            b = chain_h[1];
            c = chain_h[2];
            d = chain_h[3];
            e = chain_h[4];
            for (t = 0; t < 80; t++) begin
                if (t < 16) begin
                    nw = w[t];
                end else begin
                    nw = rol(w[(t+13) & 15] ^ w[(t+8) & 15] ^ w[(t+2) & 15] ^ w[t & 15], 1);
                    w[t & 15] = nw;
                end
                if (t < 20) begin
                    f = (b & c) | (~b & d);
                    k = 32'h5A82_7999;
                end else if (t < 40) begin
                    f = b ^ c ^ d;
                    k = 32'h6ED9_EBA1;
                end else if (t < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = 32'h8F1B_BCDC;
                end else begin
                    f = b ^ c ^ d;
                    k = 32'hCA62_C1D6;
                end
                sum = rol(a, 5) + f + e + k + nw;
                e = d;
                d = c;
                c = rol(b, 30);
                b = a;
                a = sum;
            end
            chain_h[0] += a;
            chain_h[1] += b;
            chain_h[2] += c;
            chain_h[3] += d;
            chain_h[4] += e;
        endfunction

        // one accepted input transfer
        function void note_transfer(logic [7:0] data, logic present, logic close);
            int fill;
            logic [63:0] bit_len;
            digest_beat_t beat;
            if (present) begin
                fill = int'(msg_len_bytes[5:0]);
                msg_block[fill] = data;
                msg_len_bytes = msg_len_bytes + 61'd1;
                if (fill == 63) compress_block();
            end
            if (!close) return;
            fill = int'(msg_len_bytes[5:0]);
            msg_block[fill] = 8'h80;
            for (int i = fill + 1; i < 64; i++) msg_block[i] = 8'h00;
            // no room for the length: extra block
            if (fill >= 56) begin
                compress_block();
                foreach (msg_block[i]) msg_block[i] = 8'h00;
            end
            bit_len = {msg_len_bytes, 3'b000};
            for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[63-8*i -: 8];
            compress_block();
            for (int i = 0; i < 5; i++) begin
                beat.word = chain_h[i];
                beat.index = 3'(i);
                beat.last = (i == 4);
                digest_q = {digest_q, beat};
            end
            messages++;
            restart();
        endfunction

        function int unsigned pending();
            return digest_q.size();
        endfunction

        task report(string what, logic [31:0] want, logic [31:0] got);
            $display("digest word %0d: %s, expected %h, got %h", words_checked, what, want, got);
            errors++;
        endtask

        task check_digest_word(logic [31:0] word, logic [2:0] index, logic last);
            digest_beat_t want;
            words_checked++;
            if (digest_q.size() == 0) begin
                report("no digest outstanding", '0, word);
                return;
            end
            want = digest_q.pop_front();
            if (word !== want.word) report("word mismatch", want.word, word);
            if (index !== want.index) report("index mismatch", 32'(want.index), 32'(index));
            if (last !== want.last) report("tlast mismatch", 32'(want.last), 32'(last));
        endtask

    endclass

endpackage

FILE: test/sha1_stream_hasher_test.sv
`timescale 1ns / 1ps
// Top-level test for sha1_stream_hasher: streams messages of chosen and random
// length with random idling and back-pressure, checks every digest transfer.
// Depends on sha1_digest_sb_pkg and the hasher RTL.
module sha1_stream_hasher_test;
    import sha1_digest_sb_pkg::*;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
    logic [0:0]  s_tuser  = 1'b0;    // [0] byte_present
    logic        s_tlast  = 1'b0;    // end_of_message
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // [31:0] digest_word
    logic [2:0]  m_tuser;            // [2:0] word_index
    logic        m_tlast;            // last_word

    sha1_digest_scoreboard sb = new();
    bit          quiet = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned byte_items = 0;
    int unsigned items_sent = 0;

    sha1_stream_hasher i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d digest words outstanding", sb.pending());
        $display("sha1_stream_hasher_test failed");
        $finish;
    end

    task offer(logic [7:0] data, logic present, logic close);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= present;
        s_tlast  <= close;
        do @(posedge aclk); while (!s_tready);
        sb.note_transfer(data, present, close);
        items_sent++;
    endtask

    task wait_for_digests();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // random bytes, stray idle transfers, closed with the last byte or an empty close
    task send_message(int unsigned len);
        bit closed;
        closed = 1'b0;
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 11) == 0) offer(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            closed = (i == len - 1) && ($urandom_range(0, 1) == 1);
            offer(8'($urandom_range(0, 255)), 1'b1, closed);
            byte_items++;
        end
        if (!closed) offer(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // digest side
    initial begin
        int unsigned hold_left;
        int unsigned stall_left;
        hold_left = 0;
        stall_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_digest_word(m_tdata, m_tuser, m_tlast);
            if (hold_request) begin
                hold_left = 400;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
            end
        end
    end

    // message side
    initial begin
        int unsigned len;
        int unsigned msg_no;
        int unsigned pick;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        offer(8'hFF, 1'b0, 1'b0);       // idle transfer
        offer(8'h00, 1'b0, 1'b1);       // empty message
        offer(8'h00, 1'b1, 1'b1);
        offer(8'hFF, 1'b1, 1'b1);
        offer(8'h61, 1'b1, 1'b0);       // "abc", empty close
        offer(8'h62, 1'b1, 1'b0);
        offer(8'h63, 1'b1, 1'b0);
        offer(8'hFF, 1'b0, 1'b1);
        offer(8'hA5, 1'b1, 1'b0);
        offer(8'h3C, 1'b0, 1'b0);
        offer(8'h5A, 1'b1, 1'b1);
        offer(8'h80, 1'b0, 1'b1);       // empty again right after a digest
        wait_for_digests();

        msg_no = 0;
        while (msg_no < 10 || items_sent < 220) begin
            pick = $urandom_range(0, 19);
            if (msg_no == 0) len = 55;
            else if (msg_no == 1) len = 56;
            else if (pick < 16) len = $urandom_range(0, 12);
            else if (pick < 19) len = $urandom_range(54, 66);
            else len = $urandom_range(100, 130);
            quiet = (items_sent >= 180) || ($urandom_range(0, 3) == 0);
            if (msg_no == 1) hold_request = 1'b1;
            send_message(len);
            if (msg_no == 4) wait_for_digests();
            msg_no++;
        end
        s_tvalid <= 1'b0;

        wait_for_digests();
        repeat (200) @(posedge aclk);
        $display("%0d messages hashed from %0d input transfers, %0d digest words checked",
                 sb.messages, items_sent, sb.words_checked);
        $display("covered empty, one-byte, 55/56-byte and multi-block messages under stalls");
        if (sb.errors == 0) begin
            $display("sha1_stream_hasher_test passed");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("sha1_stream_hasher_test failed");
        end
        $finish;
    end

endmodule
